/* hw/rtl/bevc_pkg.sv */
`default_nettype none
package bevc_pkg;

    // Fixed field widths
    localparam int POS_W    = 10;
    localparam int SUM_W    = 41;
    localparam int LEVEL_W  = 15;
    localparam int THR_W    = 15;
    localparam int STEPS_W  = 4;
    localparam int SQ_W     = 31;
    localparam int LO_SPLIT = 21;
    localparam int ADDR_W   = 5;

    localparam logic [POS_W-1:0]   POS_MAX   = 10'd1023;
    localparam logic [LEVEL_W-1:0] Q15_FULL  = 15'd32767;
    localparam int                 Q15_SHIFT = 15;

    // Register indexes (word address paddr[4:2])
    localparam logic [2:0] REG_LOW_FIRST  = 3'd0;
    localparam logic [2:0] REG_LOW_STOP   = 3'd1;
    localparam logic [2:0] REG_HIGH_FIRST = 3'd2;
    localparam logic [2:0] REG_HIGH_STOP  = 3'd3;
    localparam logic [2:0] REG_RATIO_THR  = 3'd4;

    // Register reset values
    localparam logic [POS_W-1:0] RST_LOW_FIRST  = 10'd1;
    localparam logic [POS_W-1:0] RST_LOW_STOP   = 10'd64;
    localparam logic [POS_W-1:0] RST_HIGH_FIRST = 10'd64;
    localparam logic [POS_W-1:0] RST_HIGH_STOP  = 10'd256;
    localparam logic [THR_W-1:0] RST_RATIO_THR  = 15'd16384;

    typedef struct packed {
        logic signed [15:0] real_part;
        logic signed [15:0] imag_part;
        logic               frame_end;
    } bevc_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] mix_ratio;
        logic               hard_decision;
    } bevc_out_t;

    typedef struct packed {
        logic [POS_W-1:0] low_first;
        logic [POS_W-1:0] low_stop;
        logic [POS_W-1:0] high_first;
        logic [POS_W-1:0] high_stop;
        logic [THR_W-1:0] ratio_thr;
    } bevc_cfg_t;

    typedef struct packed {
        logic accept;
        logic mult;
        logic decide;
    } bevc_cmd_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_MULT,
        ST_DECIDE
    } bevc_state_t;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } bevc_head_t;

endpackage
`default_nettype wire

/* hw/rtl/band_energy_vad_crossfade_unit.sv */
// Result: a frame's result is shown once its last bin has passed the DRAIN1, DRAIN2, MULT and
// DECIDE states; DECIDE waits while the previous result still waits to be taken.
// Throughput: one bin per cycle within a frame; after the last bin of a frame no input is
// taken while the frame is squared, accumulated, scaled by the threshold and decided.
// Reset: aresetn is synchronous and active low; it clears the counters, sums,
// fade state and output valid, and returns the registers to their defaults.
`default_nettype none
module band_energy_vad_crossfade_unit #(
    parameter int BIN_COUNT   = 513,
    parameter int RAMP_FRAMES = 2
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // bin stream
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire bevc_pkg::bevc_in_t                  s_data,
    // result stream
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output bevc_pkg::bevc_out_t                      m_data,
    // register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bevc_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    bevc_pkg::bevc_cfg_t cfg_reg, cfg_next;
    bevc_pkg::bevc_cmd_t cmd;
    logic                wr_en;
    logic [2:0]          reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bevc_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                bevc_pkg::REG_LOW_FIRST:  cfg_next.low_first  = pwdata[bevc_pkg::POS_W-1:0];
                bevc_pkg::REG_LOW_STOP:   cfg_next.low_stop   = pwdata[bevc_pkg::POS_W-1:0];
                bevc_pkg::REG_HIGH_FIRST: cfg_next.high_first = pwdata[bevc_pkg::POS_W-1:0];
                bevc_pkg::REG_HIGH_STOP:  cfg_next.high_stop  = pwdata[bevc_pkg::POS_W-1:0];
                bevc_pkg::REG_RATIO_THR:  cfg_next.ratio_thr  = pwdata[bevc_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            bevc_pkg::REG_LOW_FIRST:  prdata = 32'(cfg_reg.low_first);
            bevc_pkg::REG_LOW_STOP:   prdata = 32'(cfg_reg.low_stop);
            bevc_pkg::REG_HIGH_FIRST: prdata = 32'(cfg_reg.high_first);
            bevc_pkg::REG_HIGH_STOP:  prdata = 32'(cfg_reg.high_stop);
            bevc_pkg::REG_RATIO_THR:  prdata = 32'(cfg_reg.ratio_thr);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_first  <= bevc_pkg::RST_LOW_FIRST;
            cfg_reg.low_stop   <= bevc_pkg::RST_LOW_STOP;
            cfg_reg.high_first <= bevc_pkg::RST_HIGH_FIRST;
            cfg_reg.high_stop  <= bevc_pkg::RST_HIGH_STOP;
            cfg_reg.ratio_thr  <= bevc_pkg::RST_RATIO_THR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bevc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .frame_end (s_data.frame_end),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    bevc_dp #(
        .BIN_COUNT   (BIN_COUNT),
        .RAMP_FRAMES (RAMP_FRAMES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_data),
        .cfg      (cfg_reg),
        .out_data (m_data)
    );

    // A frame's last beat closes the input until its decision is made
    a_close_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.frame_end) |=> !s_ready)
        else $error("input still open after frame end");

    // A decision never overwrites a result still waiting
    a_decide_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> (!m_valid || m_ready))
        else $error("decision overwrote a pending result");

    // A result appears only from a decision
    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.decide))
        else $error("result without a decision");

    // No bin is taken while a decision is in flight
    a_no_accept_on_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mult || cmd.decide) |-> !s_ready)
        else $error("input open during decision");

endmodule
`default_nettype wire

/* hw/rtl/bevc_ctrl.sv */
`default_nettype none
module bevc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              frame_end,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bevc_pkg::bevc_cmd_t    cmd
);

    bevc_pkg::bevc_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bevc_pkg::ST_ACCUM;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            bevc_pkg::ST_ACCUM: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && frame_end) begin
                    state_next = bevc_pkg::ST_DRAIN1;
                end
            end
            bevc_pkg::ST_DRAIN1: begin
                state_next = bevc_pkg::ST_DRAIN2;
            end
            bevc_pkg::ST_DRAIN2: begin
                state_next = bevc_pkg::ST_MULT;
            end
            bevc_pkg::ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = bevc_pkg::ST_DECIDE;
            end
            bevc_pkg::ST_DECIDE: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.decide = 1'b1;
                    state_next = bevc_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = bevc_pkg::ST_ACCUM;
            end
        endcase

        if (cmd.decide) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

/* hw/rtl/bevc_dp.sv */
`default_nettype none
module bevc_dp #(
    parameter int BIN_COUNT   = 513,
    parameter int RAMP_FRAMES = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bevc_pkg::bevc_cmd_t  cmd,
    input  wire bevc_pkg::bevc_in_t   in_data,
    input  wire bevc_pkg::bevc_cfg_t  cfg,
    output bevc_pkg::bevc_out_t       out_data
);

    localparam int POS_W   = bevc_pkg::POS_W;
    localparam int SUM_W   = bevc_pkg::SUM_W;
    localparam int LEVEL_W = bevc_pkg::LEVEL_W;
    localparam int THR_W   = bevc_pkg::THR_W;
    localparam int STEPS_W = bevc_pkg::STEPS_W;
    localparam int SQ_W    = bevc_pkg::SQ_W;
    localparam int LO_W    = bevc_pkg::LO_SPLIT;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PROD_W  = SUM_W + THR_W;

    localparam logic [LEVEL_W-1:0] FADE_STEP = LEVEL_W'(32767 / RAMP_FRAMES);
    localparam logic [STEPS_W-1:0] FADE_LEN  = STEPS_W'(RAMP_FRAMES);

    // Bin counter and band membership
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             in_range, low_hit, high_hit;

    // Pipeline stages
    logic                     valid1_reg, low1_reg, high1_reg;
    logic signed [15:0]       re1_reg, im1_reg;
    logic                     valid2_reg, low2_reg, high2_reg;
    logic [SQ_W-1:0]          rr_reg, ii_reg, rr_next, ii_next;
    logic signed [31:0]       rr_full, ii_full;
    logic [SQ_W:0]            energy;
    logic [SUM_W-1:0]         low_sum_reg, high_sum_reg, low_sum_next, high_sum_next;

    // Threshold products and decision
    logic [LO_W+THR_W-1:0]    lo_pp_reg;
    logic [HI_W+THR_W-1:0]    hi_pp_reg;
    logic [PROD_W-1:0]        prod_full;
    logic [SUM_W-1:0]         scaled;
    logic                     decision;

    // Fade state
    logic                     prev_reg, prev_next;
    logic [STEPS_W-1:0]       steps_reg, steps_next, steps_eff;
    bevc_pkg::bevc_head_t     head_reg, head_next, head_eff;
    logic [LEVEL_W-1:0]       level_reg, level_next, level_step;
    logic [LEVEL_W:0]         level_up;
    bevc_pkg::bevc_out_t      out_reg, out_next;

    // Classify the incoming bin against both bands and advance the bin counter
    always_comb begin
        in_range = {1'b0, pos_reg} < (POS_W + 1)'(BIN_COUNT);
        low_hit  = in_range && (pos_reg >= cfg.low_first) && (pos_reg < cfg.low_stop);
        high_hit = in_range && (pos_reg >= cfg.high_first) && (pos_reg < cfg.high_stop);
        pos_next = pos_reg;
        if (cmd.accept) begin
            if (in_data.frame_end) begin
                pos_next = '0;
            end else if (pos_reg != bevc_pkg::POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Square both parts
    always_comb begin
        rr_full = re1_reg * re1_reg;
        ii_full = im1_reg * im1_reg;
        rr_next = rr_full[SQ_W-1:0];
        ii_next = ii_full[SQ_W-1:0];
    end

    // Accumulate, clear once the frame is decided
    always_comb begin
        energy        = {1'b0, rr_reg} + {1'b0, ii_reg};
        low_sum_next  = low_sum_reg;
        high_sum_next = high_sum_reg;
        if (cmd.decide) begin
            low_sum_next  = '0;
            high_sum_next = '0;
        end else if (valid2_reg) begin
            if (low2_reg) begin
                low_sum_next = low_sum_reg + SUM_W'(energy);
            end
            if (high2_reg) begin
                high_sum_next = high_sum_reg + SUM_W'(energy);
            end
        end
    end

    // Combine the partial products and compare
    always_comb begin
        prod_full = {hi_pp_reg, {LO_W{1'b0}}} + PROD_W'(lo_pp_reg);
        scaled    = prod_full[PROD_W-1:bevc_pkg::Q15_SHIFT];
        decision  = high_sum_reg > scaled;
    end

    // Advance the crossfade ramp
    always_comb begin
        steps_eff = steps_reg;
        head_eff  = head_reg;
        if (prev_reg != decision) begin
            steps_eff = FADE_LEN;
            head_eff  = decision ? bevc_pkg::HEAD_UP : bevc_pkg::HEAD_DOWN;
        end

        level_up = {1'b0, level_reg} + {1'b0, FADE_STEP};
        case (head_eff)
            bevc_pkg::HEAD_UP: begin
                level_step = (level_up > {1'b0, bevc_pkg::Q15_FULL}) ?
                             bevc_pkg::Q15_FULL : level_up[LEVEL_W-1:0];
            end
            bevc_pkg::HEAD_DOWN: begin
                level_step = (level_reg > FADE_STEP) ? level_reg - FADE_STEP : '0;
            end
            default: begin
                level_step = level_reg;
            end
        endcase

        if (steps_eff != '0) begin
            steps_next = steps_eff - 1'b1;
            if (steps_next == '0) begin
                level_next = (head_eff == bevc_pkg::HEAD_UP) ? bevc_pkg::Q15_FULL : '0;
                head_next  = bevc_pkg::HEAD_NONE;
            end else begin
                level_next = level_step;
                head_next  = head_eff;
            end
        end else begin
            steps_next = steps_eff;
            head_next  = head_eff;
            level_next = decision ? bevc_pkg::Q15_FULL : '0;
        end

        prev_next              = decision;
        out_next.mix_ratio     = level_next;
        out_next.hard_decision = decision;
    end

    // Control and decision state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            valid1_reg   <= 1'b0;
            valid2_reg   <= 1'b0;
            low_sum_reg  <= '0;
            high_sum_reg <= '0;
            prev_reg     <= 1'b0;
            steps_reg    <= '0;
            head_reg     <= bevc_pkg::HEAD_NONE;
            level_reg    <= '0;
        end else begin
            pos_reg      <= pos_next;
            valid1_reg   <= cmd.accept;
            valid2_reg   <= valid1_reg;
            low_sum_reg  <= low_sum_next;
            high_sum_reg <= high_sum_next;
            if (cmd.decide) begin
                prev_reg  <= prev_next;
                steps_reg <= steps_next;
                head_reg  <= head_next;
                level_reg <= level_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        low1_reg  <= low_hit;
        high1_reg <= high_hit;
        re1_reg   <= in_data.real_part;
        im1_reg   <= in_data.imag_part;
        low2_reg  <= low1_reg;
        high2_reg <= high1_reg;
        rr_reg    <= rr_next;
        ii_reg    <= ii_next;
        if (cmd.mult) begin
            lo_pp_reg <= low_sum_reg[LO_W-1:0] * cfg.ratio_thr;
            hi_pp_reg <= low_sum_reg[SUM_W-1:LO_W] * cfg.ratio_thr;
        end
        if (cmd.decide) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire
